FILE: rtl/pcm_sample_packetizer_macros.svh
`ifndef PCM_SAMPLE_PACKETIZER_MACROS_SVH
`define PCM_SAMPLE_PACKETIZER_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define PCMPK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define PCMPK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pcmpk_pkg.sv
`timescale 1ns / 1ps

package pcmpk_pkg;

    localparam int CHUNK_SAMPLES = 80;
    localparam int BLOCK_SAMPLES = 512;
    localparam int COUNT_CAP     = (CHUNK_SAMPLES < BLOCK_SAMPLES) ? CHUNK_SAMPLES
                                                                   : BLOCK_SAMPLES;

    localparam int RAW_W   = 32;
    localparam int PCM_W   = 16;
    localparam int SEQ_W   = 16;
    localparam int CNT_W   = 7;
    localparam int LEFT_W  = 10;
    localparam int SHIFT_W = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;
    localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_START  = 1'b1
    } req_t;

    typedef struct packed
    {
        logic                     req_type;
        logic signed [RAW_W-1:0]  raw_sample;
        logic [LEFT_W-1:0]        samples_left;
    } item_t;

    typedef struct packed
    {
        logic                     is_header;
        logic [SEQ_W-1:0]         seq_number;
        logic [CNT_W-1:0]         sample_count;
        logic signed [PCM_W-1:0]  pcm;
        logic                     packet_last;
    } result_t;

    typedef struct packed
    {
        logic consume;
        logic emit;
    } ctl_t;

endpackage

FILE: rtl/pcm_sample_packetizer.sv
`timescale 1ns / 1ps
// A request goes into the input register, its result into the result register.
// A packet-start sample puts its header, then its payload, in the single result register.
// Throughput: one request per cycle unless out_stall holds; packet-start samples also stall.
// Reset (rst_n, async, active low): empties both registers, clears sequence and packet
// position, loads shift_amount with 14.

`include "pcm_sample_packetizer_macros.svh"

module pcm_sample_packetizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pcmpk_pkg::SHIFT_W-1:0]       cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [pcmpk_pkg::RAW_W-1:0]  raw_sample,
    input  logic [pcmpk_pkg::LEFT_W-1:0]        samples_left,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_header,
    output logic [pcmpk_pkg::SEQ_W-1:0]         seq_number,
    output logic [pcmpk_pkg::CNT_W-1:0]         sample_count,
    output logic signed [pcmpk_pkg::PCM_W-1:0]  pcm,
    output logic                                packet_last
);

    logic [pcmpk_pkg::SHIFT_W-1:0]       shift_reg;
    logic                                in_valid_reg;
    logic                                in_valid_next;
    pcmpk_pkg::item_t                    item_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    pcmpk_pkg::result_t                  result_reg;
    logic                                out_free;
    logic signed [pcmpk_pkg::PCM_W-1:0]  pcm_val;
    pcmpk_pkg::ctl_t                     ctl;
    pcmpk_pkg::result_t                  result;
    logic                                in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !ctl.consume;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !ctl.consume);
    assign out_valid_next = ctl.emit || (out_valid_reg && out_stall);

    pcmpk_shift_sat u_shift_sat
    (
        .raw_sample   (item_reg.raw_sample),
        .shift_amount (shift_reg),
        .pcm          (pcm_val)
    );

    pcmpk_framer u_framer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (item_reg),
        .pcm        (pcm_val),
        .out_free   (out_free),
        .ctl        (ctl),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= pcmpk_pkg::SHIFT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                shift_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type     <= req_type;
            item_reg.raw_sample   <= raw_sample;
            item_reg.samples_left <= samples_left;
        end
        if (ctl.emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_header    = result_reg.is_header;
    assign seq_number   = result_reg.seq_number;
    assign sample_count = result_reg.sample_count;
    assign pcm          = result_reg.pcm;
    assign packet_last  = result_reg.packet_last;

    `PCMPK_ASSERT_NEXT(a_payload_after_header,
        out_valid && !out_stall && is_header, out_valid && !is_header,
        "header not followed by its payload")
    `PCMPK_ASSERT_SAME(a_count_range, out_valid && is_header,
        sample_count != '0 && sample_count <= pcmpk_pkg::CNT_W'(pcmpk_pkg::COUNT_CAP),
        "header count out of range")
    `PCMPK_ASSERT_SAME(a_payload_clean, out_valid && !is_header,
        seq_number == '0 && sample_count == '0, "payload carries header fields")
    `PCMPK_ASSERT_SAME(a_stall_held, in_stall, in_valid_reg,
        "input stalled with empty input register")

endmodule

FILE: rtl/pcmpk_shift_sat.sv
`timescale 1ns / 1ps

module pcmpk_shift_sat
(
    input  logic signed [pcmpk_pkg::RAW_W-1:0]   raw_sample,
    input  logic [pcmpk_pkg::SHIFT_W-1:0]        shift_amount,
    output logic signed [pcmpk_pkg::PCM_W-1:0]   pcm
);

    logic signed [pcmpk_pkg::RAW_W-1:0] shifted;
    logic                               fits;

    assign shifted = raw_sample >>> shift_amount;
    assign fits    = (shifted[pcmpk_pkg::RAW_W-1:pcmpk_pkg::PCM_W-1]
                      == {(pcmpk_pkg::RAW_W-pcmpk_pkg::PCM_W+1){shifted[pcmpk_pkg::PCM_W-1]}});

    always_comb
    begin
        if (fits)
        begin
            pcm = shifted[pcmpk_pkg::PCM_W-1:0];
        end
        else if (shifted[pcmpk_pkg::RAW_W-1])
        begin
            pcm = pcmpk_pkg::PCM_MIN;
        end
        else
        begin
            pcm = pcmpk_pkg::PCM_MAX;
        end
    end

endmodule

FILE: rtl/pcmpk_framer.sv
`timescale 1ns / 1ps

module pcmpk_framer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  pcmpk_pkg::item_t                    item,
    input  logic signed [pcmpk_pkg::PCM_W-1:0]  pcm,
    input  logic                                out_free,
    output pcmpk_pkg::ctl_t                     ctl,
    output pcmpk_pkg::result_t                  result
);

    logic [pcmpk_pkg::SEQ_W-1:0]  seq_reg;
    logic [pcmpk_pkg::SEQ_W-1:0]  seq_next;
    logic [pcmpk_pkg::CNT_W-1:0]  chunk_reg;
    logic [pcmpk_pkg::CNT_W-1:0]  chunk_next;
    logic [pcmpk_pkg::LEFT_W-1:0] left_min1;
    logic [pcmpk_pkg::CNT_W-1:0]  count;

    assign left_min1 = (item.samples_left == '0) ? pcmpk_pkg::LEFT_W'(1) : item.samples_left;
    assign count     = (left_min1 < pcmpk_pkg::LEFT_W'(pcmpk_pkg::COUNT_CAP))
                       ? left_min1[pcmpk_pkg::CNT_W-1:0]
                       : pcmpk_pkg::CNT_W'(pcmpk_pkg::COUNT_CAP);

    always_comb
    begin
        ctl        = '0;
        result     = '0;
        seq_next   = seq_reg;
        chunk_next = chunk_reg;
        if (item_valid)
        begin
            if (item.req_type == pcmpk_pkg::REQ_START)
            begin
                ctl.consume = 1'b1;
                seq_next    = '0;
                chunk_next  = '0;
            end
            else if (out_free)
            begin
                ctl.emit = 1'b1;
                if (chunk_reg == '0)
                begin
                    // header first; the same request then becomes payload
                    result.is_header    = 1'b1;
                    result.seq_number   = seq_reg;
                    result.sample_count = count;
                    seq_next            = seq_reg + pcmpk_pkg::SEQ_W'(1);
                    chunk_next          = count;
                end
                else
                begin
                    ctl.consume        = 1'b1;
                    result.pcm         = pcm;
                    result.packet_last = (chunk_reg == pcmpk_pkg::CNT_W'(1));
                    chunk_next         = chunk_reg - pcmpk_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule
